FILE: src/nqps_pkg.sv
// ----------------------------------------------------------------------------
// nqps_pkg
// Shared types and constants for the NUMA queue placement and steal block:
// command codes, register indexes, the steal candidate record and the
// constant quotient table used for distance scoring.
// ----------------------------------------------------------------------------
package nqps_pkg;

   localparam int NODE_BITS = 3;
   localparam int DIST_BITS = 8;
   localparam int QUOT_BITS = 7;
   localparam int CSR_DATA_BITS = 16;

   typedef enum logic [1:0] {
      CMD_ADD        = 2'd0,
      CMD_GET        = 2'd1,
      CMD_WRITE_DIST = 2'd2,
      CMD_UNUSED     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      CSR_NODE_COUNT     = 2'd0,
      CSR_PRESENT_MASK   = 2'd1,
      CSR_NEAR_THRESHOLD = 2'd2,
      CSR_LOAD_THRESHOLD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                 valid;
      logic                 near;
      logic [NODE_BITS-1:0] idx;
   } cand_type;

   typedef logic [QUOT_BITS-1:0] quot_table_type [256];

   // Entry d holds 100 / d, with a zero distance scored as one.
   function automatic quot_table_type build_quot100();
      quot_table_type t;
      int             q;
      int             d_eff;
      for (int d = 0; d < 256; d++) begin
         d_eff = (d == 0) ? 1 : d;
         q = 0;
         for (int k = 1; k <= 100; k++) begin
            if (k * d_eff <= 100) begin
               q++;
            end
         end
         t[d] = QUOT_BITS'(q);
      end
      return t;
   endfunction

   localparam quot_table_type QUOT100 = build_quot100();

endpackage

FILE: src/nqps_count_store.sv
// ----------------------------------------------------------------------------
// nqps_count_store
// Ready-task count memory with one write port and one registered read port.
// Per-entry valid bits make every entry read as zero after reset.
// ----------------------------------------------------------------------------
module nqps_count_store #(
   parameter int DEPTH = 8,
   parameter int WIDTH = 16
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [WIDTH-1:0] rd_data_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= vld_ff[rd_addr] ? mem_ff[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/nqps_dist_store.sv
// ----------------------------------------------------------------------------
// nqps_dist_store
// Node distance memory, one write port and one registered read port.
// Entries hold no value until written.
// ----------------------------------------------------------------------------
module nqps_dist_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 8
) (
   input  logic                                     clock,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data,
   input  logic                                     wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/nqps_score.sv
// ----------------------------------------------------------------------------
// nqps_score
// Scoring stage for steal candidates. Registers the near test, the distance
// quotient from the constant table and the load times the reciprocal of five,
// and presents their summed score combinationally from those registers.
// ----------------------------------------------------------------------------
module nqps_score import nqps_pkg::*; #(
   parameter int COUNT_BITS = 16
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  cand_type                                        src_cand,
   input  logic [COUNT_BITS-1:0]                           cnt_value,
   input  logic [DIST_BITS-1:0]                            dist_value,
   input  logic [DIST_BITS-1:0]                            near_threshold,
   input  logic [CSR_DATA_BITS-1:0]                        load_threshold,
   output cand_type                                        cand,
   output logic [(COUNT_BITS > 7 ? COUNT_BITS : 7):0]      score,
   output logic [COUNT_BITS-1:0]                           load
);

   localparam int SCORE_BITS = (COUNT_BITS > 7 ? COUNT_BITS : 7) + 1;
   localparam int CMP_BITS = (COUNT_BITS > CSR_DATA_BITS) ? COUNT_BITS : CSR_DATA_BITS;
   localparam int PROD_BITS = 2 * COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] RECIP =
      COUNT_BITS'(((64'd1 << (COUNT_BITS + 2)) / 64'd5) + 64'd1);

   cand_type               cand_ff;
   cand_type               cand_in;
   logic [PROD_BITS-1:0]   prod_ff;
   logic [PROD_BITS-1:0]   prod_in;
   logic [QUOT_BITS-1:0]   quot_ff;
   logic [QUOT_BITS-1:0]   quot_in;
   logic [COUNT_BITS-1:0]  load_ff;
   logic [COUNT_BITS-1:0]  load_in;

   always_comb begin
      cand_in.valid = src_cand.valid && (cnt_value != '0);
      cand_in.near  = (dist_value < near_threshold) &&
                      (CMP_BITS'(cnt_value) > CMP_BITS'(load_threshold));
      cand_in.idx   = src_cand.idx;
      prod_in       = PROD_BITS'(cnt_value) * PROD_BITS'(RECIP);
      quot_in       = QUOT100[dist_value];
      load_in       = cnt_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
      end else begin
         cand_ff <= cand_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      quot_ff <= quot_in;
      load_ff <= load_in;
   end

   assign cand  = cand_ff;
   assign score = SCORE_BITS'(prod_ff[PROD_BITS-1:COUNT_BITS+2]) + SCORE_BITS'(quot_ff);
   assign load  = load_ff;

endmodule

FILE: src/numa_queue_placement_and_steal.sv
// ----------------------------------------------------------------------------
// numa_queue_placement_and_steal
// Requests are handled one at a time. A distance write, command 3, or an add
// or get refused at decode is answered from decode; an add, or a get served
// locally, first reads its count; a steal reads one count and distance per
// node in use (capped at 8), then drains the scoring pipeline. The next
// request is accepted once the result is registered, which waits while an
// earlier result beat is stalled. Reset clears counts (via valid bits), the
// pointer, state and thresholds; node count and present mask reset to one.
// ----------------------------------------------------------------------------
module numa_queue_placement_and_steal import nqps_pkg::*; #(
   parameter int MAX_NODES  = 8,
   parameter int COUNT_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_command,
   input  logic [NODE_BITS-1:0]     req_node,
   input  logic                     req_has_hint,
   input  logic [NODE_BITS-1:0]     req_column_node,
   input  logic [DIST_BITS-1:0]     req_distance_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_ok,
   output logic [NODE_BITS-1:0]     rsp_queue_index,
   output logic                     rsp_stolen
);

   localparam int CNT_AW     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int DIST_DEPTH = MAX_NODES * MAX_NODES;
   localparam int DIST_AW    = (DIST_DEPTH > 1) ? $clog2(DIST_DEPTH) : 1;
   localparam int NODE_CAP   = (MAX_NODES < 15) ? MAX_NODES : 15;
   localparam int SCORE_BITS = (COUNT_BITS > 7 ? COUNT_BITS : 7) + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_ADD_CHECK,
      ST_GET_OWN,
      ST_SCAN,
      ST_DRAIN,
      ST_RESPOND
   } state_type;

   state_type               state_ff, state_in;

   logic [1:0]              cmd_ff;
   logic [NODE_BITS-1:0]    node_ff;
   logic                    hint_ff;
   logic [NODE_BITS-1:0]    col_ff;
   logic [DIST_BITS-1:0]    dval_ff;

   logic [3:0]              node_count_ff;
   logic [7:0]              present_mask_ff;
   logic [DIST_BITS-1:0]    near_thr_ff;
   logic [CSR_DATA_BITS-1:0] load_thr_ff;

   logic [NODE_BITS-1:0]    rr_ptr_ff, rr_ptr_in;
   logic [NODE_BITS-1:0]    tgt_ff, tgt_in;
   logic [NODE_BITS-1:0]    scan_q_ff, scan_q_in;
   cand_type                s0_ff, s0_in;

   logic                    res_ok_ff, res_ok_in;
   logic [NODE_BITS-1:0]    res_qi_ff, res_qi_in;
   logic                    res_stolen_ff, res_stolen_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic [NODE_BITS-1:0]    rsp_qi_ff, rsp_qi_in;
   logic                    rsp_stolen_ff, rsp_stolen_in;

   logic [SCORE_BITS-1:0]   best_score_ff, best_score_in;
   logic [NODE_BITS-1:0]    best_idx_ff, best_idx_in;
   logic [COUNT_BITS-1:0]   best_load_ff, best_load_in;
   logic                    chosen_ff, chosen_in;
   logic                    locked_ff, locked_in;

   logic                    accept;
   logic [3:0]              nodes;
   logic [7:0]              eligible;
   logic [NODE_BITS-1:0]    req_idx;
   logic [NODE_BITS-1:0]    last_q;
   logic [NODE_BITS-1:0]    rr_start;
   logic [NODE_BITS-1:0]    rr_low;
   logic [NODE_BITS-1:0]    rr_high;
   logic                    rr_high_found;
   logic                    rr_found;
   logic [NODE_BITS-1:0]    rr_target;
   logic [NODE_BITS-1:0]    rr_next;
   logic                    dist_write_ok;

   logic [CNT_AW-1:0]       cnt_rd_addr;
   logic [COUNT_BITS-1:0]   cnt_rd_data;
   logic                    cnt_wr_en;
   logic [CNT_AW-1:0]       cnt_wr_addr;
   logic [COUNT_BITS-1:0]   cnt_wr_data;
   logic [DIST_AW-1:0]      dist_rd_addr;
   logic [DIST_BITS-1:0]    dist_rd_data;
   logic                    dist_wr_en;
   logic [DIST_AW-1:0]      dist_wr_addr;

   cand_type                s1_cand;
   logic [SCORE_BITS-1:0]   s1_score;
   logic [COUNT_BITS-1:0]   s1_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // Node usage and round-robin search.
   always_comb begin
      if (node_count_ff == 4'd0) begin
         nodes = 4'd1;
      end else if (node_count_ff > 4'(NODE_CAP)) begin
         nodes = 4'(NODE_CAP);
      end else begin
         nodes = node_count_ff;
      end
      for (int i = 0; i < 8; i++) begin
         eligible[i] = present_mask_ff[i] && (4'(i) < nodes);
      end
      req_idx  = (nodes > 4'd1) ? node_ff : '0;
      last_q   = (nodes >= 4'd8) ? 3'd7 : 3'(nodes - 4'd1);
      rr_start = ({1'b0, rr_ptr_ff} < nodes) ? rr_ptr_ff : '0;
      rr_low        = '0;
      rr_high       = '0;
      rr_high_found = 1'b0;
      for (int i = 7; i >= 0; i--) begin
         if (eligible[i]) begin
            rr_low = 3'(i);
            if (3'(i) >= rr_start) begin
               rr_high       = 3'(i);
               rr_high_found = 1'b1;
            end
         end
      end
      rr_found  = |eligible;
      rr_target = rr_high_found ? rr_high : rr_low;
      rr_next   = (({1'b0, rr_target} + 4'd1) == nodes) ? '0 : rr_target + 3'd1;
      dist_write_ok = (int'(node_ff) < MAX_NODES) && (int'(col_ff) < MAX_NODES);
   end

   always_comb begin
      state_in      = state_ff;
      rr_ptr_in     = rr_ptr_ff;
      tgt_in        = tgt_ff;
      scan_q_in     = scan_q_ff;
      s0_in         = '0;
      res_ok_in     = res_ok_ff;
      res_qi_in     = res_qi_ff;
      res_stolen_in = res_stolen_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_ok_in     = rsp_ok_ff;
      rsp_qi_in     = rsp_qi_ff;
      rsp_stolen_in = rsp_stolen_ff;
      best_score_in = best_score_ff;
      best_idx_in   = best_idx_ff;
      best_load_in  = best_load_ff;
      chosen_in     = chosen_ff;
      locked_in     = locked_ff;
      cnt_rd_addr   = CNT_AW'(tgt_ff);
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = CNT_AW'(tgt_ff);
      cnt_wr_data   = cnt_rd_data;
      dist_rd_addr  = DIST_AW'(int'(scan_q_ff) * MAX_NODES + int'(tgt_ff));
      dist_wr_en    = 1'b0;
      dist_wr_addr  = DIST_AW'(int'(node_ff) * MAX_NODES + int'(col_ff));

      // The first near candidate wins and freezes the choice; otherwise the
      // highest score wins, with ties going to the later node.
      if (s1_cand.valid && !locked_ff) begin
         if (s1_cand.near) begin
            best_idx_in  = s1_cand.idx;
            best_load_in = s1_load;
            chosen_in    = 1'b1;
            locked_in    = 1'b1;
         end else if (s1_score >= best_score_ff) begin
            best_score_in = s1_score;
            best_idx_in   = s1_cand.idx;
            best_load_in  = s1_load;
            chosen_in     = 1'b1;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_ok_in     = 1'b0;
            res_qi_in     = '0;
            res_stolen_in = 1'b0;
            state_in      = ST_RESPOND;
            unique case (cmd_type'(cmd_ff))
               CMD_ADD: begin
                  if (hint_ff) begin
                     res_qi_in = node_ff;
                     if (eligible[node_ff]) begin
                        tgt_in      = node_ff;
                        cnt_rd_addr = CNT_AW'(node_ff);
                        state_in    = ST_ADD_CHECK;
                     end
                  end else if (rr_found) begin
                     rr_ptr_in   = rr_next;
                     tgt_in      = rr_target;
                     cnt_rd_addr = CNT_AW'(rr_target);
                     state_in    = ST_ADD_CHECK;
                  end
               end
               CMD_GET: begin
                  if ({1'b0, req_idx} < nodes) begin
                     tgt_in      = req_idx;
                     cnt_rd_addr = CNT_AW'(req_idx);
                     state_in    = ST_GET_OWN;
                  end
               end
               CMD_WRITE_DIST: begin
                  if (dist_write_ok) begin
                     dist_wr_en = 1'b1;
                     res_ok_in  = 1'b1;
                  end
               end
               CMD_UNUSED: begin
                  res_ok_in = 1'b0;
               end
            endcase
         end
         ST_ADD_CHECK: begin
            res_qi_in     = tgt_ff;
            res_stolen_in = 1'b0;
            state_in      = ST_RESPOND;
            if (cnt_rd_data == {COUNT_BITS{1'b1}}) begin
               res_ok_in = 1'b0;
            end else begin
               cnt_wr_en   = 1'b1;
               cnt_wr_data = cnt_rd_data + 1'b1;
               res_ok_in   = 1'b1;
            end
         end
         ST_GET_OWN: begin
            res_qi_in     = tgt_ff;
            res_stolen_in = 1'b0;
            res_ok_in     = 1'b0;
            if (eligible[tgt_ff] && (cnt_rd_data != '0)) begin
               cnt_wr_en   = 1'b1;
               cnt_wr_data = cnt_rd_data - 1'b1;
               res_ok_in   = 1'b1;
               state_in    = ST_RESPOND;
            end else if (nodes > 4'd1) begin
               scan_q_in     = '0;
               best_score_in = '0;
               best_idx_in   = '0;
               best_load_in  = '0;
               chosen_in     = 1'b0;
               locked_in     = 1'b0;
               state_in      = ST_SCAN;
            end else begin
               state_in = ST_RESPOND;
            end
         end
         ST_SCAN: begin
            cnt_rd_addr = CNT_AW'(scan_q_ff);
            s0_in.valid = (scan_q_ff != tgt_ff) && eligible[scan_q_ff];
            s0_in.near  = 1'b0;
            s0_in.idx   = scan_q_ff;
            if (scan_q_ff == last_q) begin
               state_in = ST_DRAIN;
            end else begin
               scan_q_in = scan_q_ff + 3'd1;
            end
         end
         ST_DRAIN: begin
            if (!s0_ff.valid && !s1_cand.valid) begin
               state_in = ST_RESPOND;
               if (chosen_ff) begin
                  cnt_wr_en     = 1'b1;
                  cnt_wr_addr   = CNT_AW'(best_idx_ff);
                  cnt_wr_data   = best_load_ff - 1'b1;
                  res_ok_in     = 1'b1;
                  res_qi_in     = best_idx_ff;
                  res_stolen_in = 1'b1;
               end else begin
                  res_ok_in     = 1'b0;
                  res_qi_in     = tgt_ff;
                  res_stolen_in = 1'b0;
               end
            end
         end
         ST_RESPOND: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_ok_in     = res_ok_ff;
               rsp_qi_in     = res_qi_ff;
               rsp_stolen_in = res_stolen_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rr_ptr_ff    <= '0;
         s0_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         chosen_ff    <= 1'b0;
         locked_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rr_ptr_ff    <= rr_ptr_in;
         s0_ff        <= s0_in;
         rsp_valid_ff <= rsp_valid_in;
         chosen_ff    <= chosen_in;
         locked_ff    <= locked_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_ff        <= tgt_in;
      scan_q_ff     <= scan_q_in;
      res_ok_ff     <= res_ok_in;
      res_qi_ff     <= res_qi_in;
      res_stolen_ff <= res_stolen_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_qi_ff     <= rsp_qi_in;
      rsp_stolen_ff <= rsp_stolen_in;
      best_score_ff <= best_score_in;
      best_idx_ff   <= best_idx_in;
      best_load_ff  <= best_load_in;
      if (accept) begin
         cmd_ff  <= req_command;
         node_ff <= req_node;
         hint_ff <= req_has_hint;
         col_ff  <= req_column_node;
         dval_ff <= req_distance_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff   <= 4'd1;
         present_mask_ff <= 8'd1;
         near_thr_ff     <= '0;
         load_thr_ff     <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_NODE_COUNT:     node_count_ff   <= csr_write_data[3:0];
            CSR_PRESENT_MASK:   present_mask_ff <= csr_write_data[7:0];
            CSR_NEAR_THRESHOLD: near_thr_ff     <= csr_write_data[DIST_BITS-1:0];
            CSR_LOAD_THRESHOLD: load_thr_ff     <= csr_write_data;
         endcase
      end
   end

   nqps_count_store #(
      .DEPTH (MAX_NODES),
      .WIDTH (COUNT_BITS)
   ) u_count_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (cnt_rd_addr),
      .rd_data (cnt_rd_data),
      .wr_en   (cnt_wr_en),
      .wr_addr (cnt_wr_addr),
      .wr_data (cnt_wr_data)
   );

   nqps_dist_store #(
      .DEPTH (DIST_DEPTH),
      .WIDTH (DIST_BITS)
   ) u_dist_store (
      .clock   (clock),
      .rd_addr (dist_rd_addr),
      .rd_data (dist_rd_data),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dval_ff)
   );

   nqps_score #(
      .COUNT_BITS (COUNT_BITS)
   ) u_score (
      .clock          (clock),
      .reset          (reset),
      .src_cand       (s0_ff),
      .cnt_value      (cnt_rd_data),
      .dist_value     (dist_rd_data),
      .near_threshold (near_thr_ff),
      .load_threshold (load_thr_ff),
      .cand           (s1_cand),
      .score          (s1_score),
      .load           (s1_load)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_queue_index = rsp_qi_ff;
   assign rsp_stolen      = rsp_stolen_ff;

endmodule
